// File: design/plp_pkg.sv
// shared types, constants and helpers of the pose latency predictor
// no dependencies
`default_nettype none
package plp_pkg;

  localparam int W      = 32;
  localparam int DW     = 64;
  localparam int PW     = 2 * (W + 1);
  localparam int XW     = PW + 1;
  localparam int NV     = 7;
  localparam int FRAC_T = 16;
  localparam int FRAC_Q = 30;
  localparam int SW     = 17;
  localparam int IW     = 8;

  localparam logic [SW-1:0] SMOOTH_ONE = SW'(65536);
  localparam logic signed [W-1:0] Q_ONE = W'(1073741824);
  localparam logic signed [XW-1:0] RND_HALF = XW'(32768);

  localparam logic [IW-1:0] REG_LEAD   = IW'(0);
  localparam logic [IW-1:0] REG_SMOOTH = IW'(1);

  typedef logic signed [W-1:0] word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_PRIME, OP_SPD_GO, OP_SPD_WR, OP_SM_A, OP_SM_B, OP_SM_C,
    OP_PR_A, OP_PR_B, OP_SQ_A, OP_SQ_B, OP_RT_GO, OP_ND_GO, OP_ND_WR, OP_COMMIT
  } op_t;

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_CHECK  = 16'h0002,
    S_SDIV   = 16'h0004,
    S_SWAIT  = 16'h0008,
    S_SMA    = 16'h0010,
    S_SMB    = 16'h0020,
    S_SMC    = 16'h0040,
    S_PRA    = 16'h0080,
    S_PRB    = 16'h0100,
    S_SQA    = 16'h0200,
    S_SQB    = 16'h0400,
    S_RTGO   = 16'h0800,
    S_RTWAIT = 16'h1000,
    S_NDIV   = 16'h2000,
    S_NWAIT  = 16'h4000,
    S_DONE   = 16'h8000
  } state_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic prev_zero;
    logic delta_zero;
    logic delta_neg;
    logic smooth_zero;
    logic sum_zero;
    logic div_done;
    logic sqrt_done;
    logic out_busy;
  } sts_t;

  function automatic word_t sat_x(input logic signed [XW-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    begin
      hi_ones  = &v[XW-1:W-1];
      hi_zeros = ~|v[XW-1:W-1];
      if (hi_ones || hi_zeros) begin
        sat_x = v[W-1:0];
      end else if (v[XW-1]) begin
        sat_x = {1'b1, {(W-1){1'b0}}};
      end else begin
        sat_x = {1'b0, {(W-1){1'b1}}};
      end
    end
  endfunction

  function automatic logic signed [XW-1:0] rnd_q16(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] t;
    begin
      t = v + RND_HALF;
      rnd_q16 = t >>> FRAC_T;
    end
  endfunction

endpackage
`default_nettype wire

// File: design/plp_if.sv
// channel interfaces: input pose, output pose and configuration write
// depends on plp_pkg
`default_nettype none
interface plp_in_if;
  logic valid;
  logic ready;
  plp_pkg::word_t stamp;
  plp_pkg::word_t pos_x;
  plp_pkg::word_t pos_y;
  plp_pkg::word_t pos_z;
  plp_pkg::word_t rot_x;
  plp_pkg::word_t rot_y;
  plp_pkg::word_t rot_z;
  plp_pkg::word_t rot_w;
  modport source (output valid, stamp, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w,
                  input ready);
  modport sink (input valid, stamp, pos_x, pos_y, pos_z, rot_x, rot_y, rot_z, rot_w,
                output ready);
endinterface

interface plp_out_if;
  logic valid;
  logic ready;
  plp_pkg::word_t out_stamp;
  plp_pkg::word_t out_pos_x;
  plp_pkg::word_t out_pos_y;
  plp_pkg::word_t out_pos_z;
  plp_pkg::word_t out_rot_x;
  plp_pkg::word_t out_rot_y;
  plp_pkg::word_t out_rot_z;
  plp_pkg::word_t out_rot_w;
  modport source (output valid, out_stamp, out_pos_x, out_pos_y, out_pos_z,
                  out_rot_x, out_rot_y, out_rot_z, out_rot_w, input ready);
  modport sink (input valid, out_stamp, out_pos_x, out_pos_y, out_pos_z,
                out_rot_x, out_rot_y, out_rot_z, out_rot_w, output ready);
endinterface

interface plp_cfg_if;
  logic valid;
  logic ready;
  logic [plp_pkg::IW-1:0] index;
  logic [plp_pkg::W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: design/plp_div.sv
// serial signed divider, one quotient bit per cycle, saturated 32-bit result
// depends on plp_pkg
`default_nettype none
module plp_div (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic signed [plp_pkg::DW-1:0] num,
  input  wire logic signed [plp_pkg::W:0]    den,
  output      logic                         done,
  output      plp_pkg::word_t               quot
);
  localparam int W  = plp_pkg::W;
  localparam int DW = plp_pkg::DW;
  localparam int CW = $clog2(DW + 1);

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic          neg_r, neg_nxt;
  logic [W:0]    den_r, den_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [DW-1:0] qs_r, qs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W+1:0]  trial;
  logic          big_pos;
  logic          big_neg;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    qs_nxt   = qs_r;
    cnt_nxt  = cnt_r;
    trial    = {rem_r, qs_r[DW-1]};
    if (start) begin
      run_nxt = 1'b1;
      neg_nxt = num[DW-1] ^ den[W];
      den_nxt = den[W] ? (W+1)'(-den) : den;
      qs_nxt  = num[DW-1] ? DW'(-num) : num;
      rem_nxt = '0;
      cnt_nxt = '0;
    end else if (run_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = (W+1)'(trial - {1'b0, den_r});
        qs_nxt  = {qs_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[W:0];
        qs_nxt  = {qs_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(DW - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    neg_r <= neg_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    qs_r  <= qs_nxt;
    cnt_r <= cnt_nxt;
  end

  assign big_pos = |qs_r[DW-1:W-1];
  assign big_neg = (|qs_r[DW-1:W]) || (qs_r[W-1] && (|qs_r[W-2:0]));

  always_comb begin
    if (neg_r) begin
      quot = big_neg ? {1'b1, {(W-1){1'b0}}} : W'(-qs_r[W-1:0]);
    end else begin
      quot = big_pos ? {1'b0, {(W-1){1'b1}}} : qs_r[W-1:0];
    end
  end

  assign done = done_r;
endmodule
`default_nettype wire

// File: design/plp_sqrt.sv
// serial integer square root of a 64-bit value, 32-bit result
// depends on plp_pkg
`default_nettype none
module plp_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [plp_pkg::DW-1:0] val,
  output      logic                  done,
  output      logic [plp_pkg::W-1:0]  root
);
  localparam int DW = plp_pkg::DW;

  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] res_r, res_nxt;
  logic [DW-1:0] bit_r, bit_nxt;
  logic [DW-1:0] trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    trial    = res_r + bit_r;
    if (start) begin
      run_nxt = 1'b1;
      rem_nxt = val;
      res_nxt = '0;
      bit_nxt = {2'b01, {(DW-2){1'b0}}};
    end else if (run_r) begin
      if (rem_r >= trial) begin
        rem_nxt = rem_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r[0] || bit_r[1]) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = res_r[plp_pkg::W-1:0];
endmodule
`default_nettype wire

// File: design/plp_ctrl.sv
// sequencing state machine: issues datapath commands per step and component
// depends on plp_pkg
`default_nettype none
module plp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire plp_pkg::sts_t sts,
  output      plp_pkg::cmd_t cmd
);
  plp_pkg::state_t state_r, state_nxt;
  logic [2:0]      idx_r, idx_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd.op    = plp_pkg::OP_NONE;
    cmd.idx   = idx_r;
    case (state_r)
      plp_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op    = plp_pkg::OP_LOAD;
          state_nxt = plp_pkg::S_CHECK;
        end
      end
      plp_pkg::S_CHECK: begin
        idx_nxt = '0;
        if (sts.prev_zero) begin
          cmd.op    = plp_pkg::OP_PRIME;
          state_nxt = plp_pkg::S_IDLE;
        end else if (sts.delta_zero) begin
          state_nxt = plp_pkg::S_IDLE;
        end else begin
          state_nxt = plp_pkg::S_SDIV;
        end
      end
      plp_pkg::S_SDIV: begin
        cmd.op    = plp_pkg::OP_SPD_GO;
        state_nxt = plp_pkg::S_SWAIT;
      end
      plp_pkg::S_SWAIT, plp_pkg::S_SMC: begin
        if (state_r == plp_pkg::S_SMC || sts.div_done) begin
          cmd.op = (state_r == plp_pkg::S_SMC) ? plp_pkg::OP_SM_C : plp_pkg::OP_SPD_WR;
          if (state_r == plp_pkg::S_SWAIT && !sts.smooth_zero) begin
            state_nxt = plp_pkg::S_SMA;
          end else if (idx_r == 3'd6) begin
            idx_nxt   = '0;
            state_nxt = sts.delta_neg ? plp_pkg::S_DONE : plp_pkg::S_PRA;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = plp_pkg::S_SDIV;
          end
        end
      end
      plp_pkg::S_SMA: begin
        cmd.op    = plp_pkg::OP_SM_A;
        state_nxt = plp_pkg::S_SMB;
      end
      plp_pkg::S_SMB: begin
        cmd.op    = plp_pkg::OP_SM_B;
        state_nxt = plp_pkg::S_SMC;
      end
      plp_pkg::S_PRA: begin
        cmd.op    = plp_pkg::OP_PR_A;
        state_nxt = plp_pkg::S_PRB;
      end
      plp_pkg::S_PRB: begin
        cmd.op = plp_pkg::OP_PR_B;
        if (idx_r == 3'd6) begin
          idx_nxt   = '0;
          state_nxt = plp_pkg::S_SQA;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = plp_pkg::S_PRA;
        end
      end
      plp_pkg::S_SQA: begin
        cmd.op    = plp_pkg::OP_SQ_A;
        state_nxt = plp_pkg::S_SQB;
      end
      plp_pkg::S_SQB: begin
        cmd.op = plp_pkg::OP_SQ_B;
        if (idx_r == 3'd3) begin
          idx_nxt   = '0;
          state_nxt = plp_pkg::S_RTGO;
        end else begin
          idx_nxt   = idx_r + 3'd1;
          state_nxt = plp_pkg::S_SQA;
        end
      end
      plp_pkg::S_RTGO: begin
        if (sts.sum_zero) begin
          state_nxt = plp_pkg::S_DONE;
        end else begin
          cmd.op    = plp_pkg::OP_RT_GO;
          state_nxt = plp_pkg::S_RTWAIT;
        end
      end
      plp_pkg::S_RTWAIT: begin
        if (sts.sqrt_done) begin
          state_nxt = plp_pkg::S_NDIV;
        end
      end
      plp_pkg::S_NDIV: begin
        cmd.op    = plp_pkg::OP_ND_GO;
        state_nxt = plp_pkg::S_NWAIT;
      end
      plp_pkg::S_NWAIT: begin
        if (sts.div_done) begin
          cmd.op = plp_pkg::OP_ND_WR;
          if (idx_r == 3'd3) begin
            idx_nxt   = '0;
            state_nxt = plp_pkg::S_DONE;
          end else begin
            idx_nxt   = idx_r + 3'd1;
            state_nxt = plp_pkg::S_NDIV;
          end
        end
      end
      plp_pkg::S_DONE: begin
        if (!sts.out_busy) begin
          cmd.op    = plp_pkg::OP_COMMIT;
          state_nxt = plp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = plp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plp_pkg::S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign in_ready = (state_r == plp_pkg::S_IDLE);
endmodule
`default_nettype wire

// File: design/plp_dp.sv
// datapath: pose state, config registers, shared multiplier, divider, root, output word
// depends on plp_pkg, plp_div, plp_sqrt
`default_nettype none
module plp_dp (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire plp_pkg::cmd_t          cmd,
  output      plp_pkg::sts_t          sts,
  input  wire logic                   cfg_we,
  input  wire logic [plp_pkg::IW-1:0] cfg_index,
  input  wire logic [plp_pkg::W-1:0]  cfg_data,
  input  wire plp_pkg::word_t         in_stamp,
  input  wire plp_pkg::word_t         in_vec [plp_pkg::NV],
  output      logic                   out_valid,
  input  wire logic                   out_ready,
  output      plp_pkg::word_t         out_vec [plp_pkg::NV+1]
);
  localparam int W  = plp_pkg::W;
  localparam int DW = plp_pkg::DW;
  localparam int PW = plp_pkg::PW;
  localparam int XW = plp_pkg::XW;
  localparam int NV = plp_pkg::NV;
  localparam int SW = plp_pkg::SW;

  plp_pkg::word_t lead_r;
  logic [SW-1:0]  smooth_r;
  plp_pkg::word_t prev_stamp_r;
  plp_pkg::word_t prev_v_r [NV];
  plp_pkg::word_t speed_r [NV];
  plp_pkg::word_t stamp_r;
  plp_pkg::word_t in_v_r [NV];
  plp_pkg::word_t ns_r [NV];
  plp_pkg::word_t pv_r [NV];
  plp_pkg::word_t nrm_r [4];
  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] acc_r;
  logic [DW-1:0]        sum_r;
  logic                 out_valid_r;
  plp_pkg::word_t       out_r [NV+1];

  logic signed [W:0]    delta;
  logic signed [W:0]    diff;
  logic signed [W:0]    mul_a;
  logic signed [W:0]    mul_b;
  logic [2:0]           qi;
  logic                 div_start;
  logic signed [DW-1:0] div_num;
  logic signed [W:0]    div_den;
  logic                 div_done;
  plp_pkg::word_t       div_quot;
  logic                 sqrt_done;
  logic [W-1:0]         root;
  logic [DW:0]          sum_add;
  logic signed [XW-1:0] sm_sum;
  logic signed [XW-1:0] pr_sum;
  logic [SW-1:0]        cfg_s;

  assign qi    = 3'(cmd.idx + 3'd3);
  assign delta = {stamp_r[W-1], stamp_r} - {prev_stamp_r[W-1], prev_stamp_r};
  assign diff  = {in_v_r[cmd.idx][W-1], in_v_r[cmd.idx]} -
                 {prev_v_r[cmd.idx][W-1], prev_v_r[cmd.idx]};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      plp_pkg::OP_SM_A: begin
        mul_a = {{(W+1-SW){1'b0}}, smooth_r};
        mul_b = {speed_r[cmd.idx][W-1], speed_r[cmd.idx]};
      end
      plp_pkg::OP_SM_B: begin
        mul_a = {{(W+1-SW){1'b0}}, SW'(plp_pkg::SMOOTH_ONE - smooth_r)};
        mul_b = {ns_r[cmd.idx][W-1], ns_r[cmd.idx]};
      end
      plp_pkg::OP_PR_A: begin
        mul_a = {ns_r[cmd.idx][W-1], ns_r[cmd.idx]};
        mul_b = {lead_r[W-1], lead_r};
      end
      plp_pkg::OP_SQ_A: begin
        mul_a = {pv_r[qi][W-1], pv_r[qi]};
        mul_b = {pv_r[qi][W-1], pv_r[qi]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = delta;
    case (cmd.op)
      plp_pkg::OP_SPD_GO: begin
        div_start = 1'b1;
        div_num   = {{(DW-W-1-plp_pkg::FRAC_T){diff[W]}}, diff, {plp_pkg::FRAC_T{1'b0}}};
        div_den   = delta;
      end
      plp_pkg::OP_ND_GO: begin
        div_start = 1'b1;
        div_num   = {{(DW-W-plp_pkg::FRAC_Q){pv_r[qi][W-1]}}, pv_r[qi],
                     {plp_pkg::FRAC_Q{1'b0}}};
        div_den   = {1'b0, root};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  plp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  plp_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.op == plp_pkg::OP_RT_GO),
    .val   (sum_r),
    .done  (sqrt_done),
    .root  (root)
  );

  assign sum_add = {1'b0, sum_r} + {1'b0, prod_r[DW-1:0]};
  assign sm_sum  = XW'(acc_r) + XW'(prod_r);
  assign pr_sum  = plp_pkg::rnd_q16(XW'(prod_r)) + XW'(in_v_r[cmd.idx]);
  assign cfg_s   = (cfg_data[SW-1:0] > plp_pkg::SMOOTH_ONE) ? plp_pkg::SMOOTH_ONE
                                                             : cfg_data[SW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r       <= '0;
      smooth_r     <= '0;
      prev_stamp_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        prev_v_r[i] <= '0;
        speed_r[i]  <= '0;
      end
      prev_v_r[NV-1] <= plp_pkg::Q_ONE;
      speed_r[NV-1]  <= plp_pkg::Q_ONE;
    end else begin
      if (cfg_we && cfg_index == plp_pkg::REG_LEAD) begin
        lead_r <= cfg_data;
      end
      if (cfg_we && cfg_index == plp_pkg::REG_SMOOTH) begin
        smooth_r <= cfg_s;
      end
      if (cmd.op == plp_pkg::OP_COMMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (cmd.op)
        plp_pkg::OP_PRIME: begin
          prev_stamp_r <= stamp_r;
          for (int i = 0; i < NV; i++) begin
            prev_v_r[i] <= in_v_r[i];
          end
        end
        plp_pkg::OP_COMMIT: begin
          prev_stamp_r <= stamp_r;
          for (int i = 0; i < NV; i++) begin
            prev_v_r[i] <= in_v_r[i];
            speed_r[i]  <= ns_r[i];
          end
        end
        default: begin
          prev_stamp_r <= prev_stamp_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      plp_pkg::OP_LOAD: begin
        stamp_r <= in_stamp;
        sum_r   <= '0;
        for (int i = 0; i < NV; i++) begin
          in_v_r[i] <= in_vec[i];
        end
      end
      plp_pkg::OP_SPD_WR: ns_r[cmd.idx] <= div_quot;
      plp_pkg::OP_SM_B:   acc_r <= prod_r;
      plp_pkg::OP_SM_C:   ns_r[cmd.idx] <= plp_pkg::sat_x(plp_pkg::rnd_q16(sm_sum));
      plp_pkg::OP_PR_B:   pv_r[cmd.idx] <= plp_pkg::sat_x(pr_sum);
      plp_pkg::OP_SQ_B:   sum_r <= sum_add[DW] ? {DW{1'b1}} : sum_add[DW-1:0];
      plp_pkg::OP_ND_WR:  nrm_r[cmd.idx[1:0]] <= div_quot;
      plp_pkg::OP_COMMIT: begin
        if (delta[W]) begin
          out_r[0] <= stamp_r;
          for (int i = 0; i < NV; i++) begin
            out_r[i+1] <= in_v_r[i];
          end
        end else begin
          out_r[0] <= plp_pkg::sat_x(XW'(stamp_r) + XW'(lead_r));
          for (int i = 0; i < 3; i++) begin
            out_r[i+1] <= pv_r[i];
          end
          for (int i = 0; i < 4; i++) begin
            out_r[i+4] <= (sum_r == '0) ? pv_r[i+3] : nrm_r[i];
          end
        end
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  always_comb begin
    sts.prev_zero   = (prev_stamp_r == '0);
    sts.delta_zero  = (delta == '0);
    sts.delta_neg   = delta[W];
    sts.smooth_zero = (smooth_r == '0);
    sts.sum_zero    = (sum_r == '0);
    sts.div_done    = div_done;
    sts.sqrt_done   = sqrt_done;
    sts.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_vec   = out_r;
endmodule
`default_nettype wire

// File: design/pose_latency_predictor_core.sv
// pose latency predictor top: controller, datapath and channel hookup
// depends on plp_pkg, plp_if, plp_ctrl, plp_dp
//
// channel  dir  word
// in_ch    in   stamp, pos_x/y/z, rot_x/y/z/w (signed q16.16 / q2.30)
// out_ch   out  out_stamp, out_pos_x/y/z, out_rot_x/y/z/w
// cfg_ch   in   index, data (0 lead_time, 1 smoothing)
//
// one item at a time; priming or equal-stamp words go from the check state back to idle
// speeds: 7 divisions (issue, 64 steps, write), each then SM_A/B/C when smoothing
// forward prediction adds PR_A/B for 7 components, SQ_A/B for 4 quaternion parts,
// the root and 4 such divisions; backward time skips all these, a zero quaternion the rest
// a finished word waits in the output register; the next word is taken meanwhile
// cfg_ch is always ready; rst_n is synchronous
`default_nettype none
module pose_latency_predictor_core (
  input wire logic clk,
  input wire logic rst_n,
  plp_in_if.sink   in_ch,
  plp_out_if.source out_ch,
  plp_cfg_if.sink  cfg_ch
);
  plp_pkg::cmd_t  cmd;
  plp_pkg::sts_t  sts;
  plp_pkg::word_t in_vec [plp_pkg::NV];
  plp_pkg::word_t out_vec [plp_pkg::NV+1];
  logic           in_ready;
  logic           out_valid;

  assign in_vec[0] = in_ch.pos_x;
  assign in_vec[1] = in_ch.pos_y;
  assign in_vec[2] = in_ch.pos_z;
  assign in_vec[3] = in_ch.rot_x;
  assign in_vec[4] = in_ch.rot_y;
  assign in_vec[5] = in_ch.rot_z;
  assign in_vec[6] = in_ch.rot_w;

  plp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  plp_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_stamp  (in_ch.stamp),
    .in_vec    (in_vec),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_vec   (out_vec)
  );

  assign in_ch.ready      = in_ready;
  assign cfg_ch.ready     = 1'b1;
  assign out_ch.valid     = out_valid;
  assign out_ch.out_stamp = out_vec[0];
  assign out_ch.out_pos_x = out_vec[1];
  assign out_ch.out_pos_y = out_vec[2];
  assign out_ch.out_pos_z = out_vec[3];
  assign out_ch.out_rot_x = out_vec[4];
  assign out_ch.out_rot_y = out_vec[5];
  assign out_ch.out_rot_z = out_vec[6];
  assign out_ch.out_rot_w = out_vec[7];

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == plp_pkg::OP_COMMIT |-> !(out_valid && !out_ch.ready))
    else $error("output word overwritten");
  a_valid_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.op == plp_pkg::OP_COMMIT))
    else $error("output valid without commit");
`endif
endmodule
`default_nettype wire
